// File: rtl/rhsi_pkg.sv
// Shared types and constants for the 4D ray / unit hypersphere intersect block.
// No dependencies; imported by every rtl module of the block except rhsi_fifo.
package rhsi_pkg;

   localparam int IN_W    = 24;   // input coordinate width
   localparam int DOT_W   = 49;   // magnitude of a dot product
   localparam int HALF_LO = 25;   // low half when splitting a DOT_W operand
   localparam int DISC_W  = 98;   // discriminant width
   localparam int ROOT_W  = 49;   // floor(sqrt(disc)) width
   localparam int REM_W   = ROOT_W + 2;
   localparam int DIST_W  = 32;
   localparam int NUM_W   = DOT_W + DIST_W;  // numerator shifted by the fraction bits

   typedef enum logic [1:0] {
      OUT_HIT      = 2'd0,
      OUT_NO_ROOT  = 2'd1,
      OUT_BEHIND   = 2'd2,
      OUT_ZERO_DIR = 2'd3
   } outcome_type;

   // front to back transaction
   typedef struct packed {
      logic [DISC_W-1:0] disc;
      logic [DOT_W-1:0]  a;
      logic [DOT_W-1:0]  mag_h;
      logic              h_neg;
      logic              decided;
      outcome_type       outcome;
   } job_type;

   typedef struct packed {
      logic              hit;
      logic [DIST_W-1:0] distance;
      outcome_type       outcome;
   } result_type;

endpackage

// File: rtl/rhsi_fifo.sv
// Small show-ahead queue on flops, DEPTH a power of two.
// Uses nothing from the package.
module rhsi_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ff];

   always_comb begin
      wr_in    = do_push ? wr_ff + AW'(1) : wr_ff;
      rd_in    = do_pop ? rd_ff + AW'(1) : rd_ff;
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue occupancy above depth");

endmodule

// File: rtl/rhsi_front.sv
// Front end: dot products, discriminant, early classification.
// Depends on rhsi_pkg. Six stages under one stall enable.
module rhsi_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [3:0][rhsi_pkg::IN_W-1:0]      origin,
   input  logic [3:0][rhsi_pkg::IN_W-1:0]      dir,
   output logic                                job_valid,
   output rhsi_pkg::job_type                   job,
   input  logic                                job_full
);
   import rhsi_pkg::*;

   localparam int H_W = DOT_W + 1;
   localparam logic signed [H_W-1:0] ONE = H_W'(1) << (2 * FRAC_BITS);

   logic        run;
   logic [5:0]  v_ff, v_in;

   // stage 1
   logic signed [2*IN_W-1:0] dd_ff [4], do_ff [4], oo_ff [4];
   // stage 2
   logic [DOT_W-1:0]         a2_ff, oo2_ff;
   logic signed [H_W-1:0]    h2_ff;
   // stage 3
   logic [DOT_W-1:0]         a3_ff, mh3_ff, mc3_ff;
   logic                     hn3_ff, cle3_ff, z3_ff;
   logic signed [H_W-1:0]    c_in;
   // stage 4
   logic [2*HALF_LO-1:0]     hll_ff, hlh_ff, hhh_ff, all_ff, alh_ff, ahl_ff, ahh_ff;
   logic [DOT_W-1:0]         a4_ff, mh4_ff;
   logic                     hn4_ff, cle4_ff, z4_ff;
   // stage 5
   logic [DISC_W-1:0]        hsq5_ff, ac5_ff;
   logic [DOT_W-1:0]         a5_ff, mh5_ff;
   logic                     hn5_ff, cle5_ff, z5_ff;
   // stage 6
   job_type                  job_ff, job_in;
   logic [DISC_W:0]          diff;

   assign run       = !(v_ff[5] && job_full);
   assign in_ready  = run;
   assign job_valid = v_ff[5];
   assign job       = job_ff;
   assign v_in      = {v_ff[4:0], in_valid};
   assign c_in      = $signed({1'b0, oo2_ff}) - ONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (run) begin
         v_ff <= v_in;
      end
   end

   always_comb begin
      diff   = {1'b0, hsq5_ff} - {1'b0, ac5_ff};
      job_in.a       = a5_ff;
      job_in.mag_h   = mh5_ff;
      job_in.h_neg   = hn5_ff;
      job_in.disc    = cle5_ff ? hsq5_ff + ac5_ff : diff[DISC_W-1:0];
      job_in.decided = 1'b0;
      job_in.outcome = OUT_HIT;
      if (z5_ff) begin
         job_in.decided = 1'b1;
         job_in.outcome = OUT_ZERO_DIR;
      end else if (!cle5_ff && diff[DISC_W]) begin
         job_in.decided = 1'b1;
         job_in.outcome = OUT_NO_ROOT;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         for (int i = 0; i < 4; i++) begin
            dd_ff[i] <= $signed(dir[i]) * $signed(dir[i]);
            do_ff[i] <= $signed(dir[i]) * $signed(origin[i]);
            oo_ff[i] <= $signed(origin[i]) * $signed(origin[i]);
         end
         a2_ff  <= DOT_W'($unsigned(dd_ff[0])) + DOT_W'($unsigned(dd_ff[1]))
                 + DOT_W'($unsigned(dd_ff[2])) + DOT_W'($unsigned(dd_ff[3]));
         oo2_ff <= DOT_W'($unsigned(oo_ff[0])) + DOT_W'($unsigned(oo_ff[1]))
                 + DOT_W'($unsigned(oo_ff[2])) + DOT_W'($unsigned(oo_ff[3]));
         h2_ff  <= H_W'(do_ff[0]) + H_W'(do_ff[1]) + H_W'(do_ff[2]) + H_W'(do_ff[3]);

         a3_ff   <= a2_ff;
         hn3_ff  <= h2_ff[H_W-1];
         mh3_ff  <= h2_ff[H_W-1] ? DOT_W'(-h2_ff) : DOT_W'(h2_ff);
         cle3_ff <= (c_in <= 0);
         mc3_ff  <= c_in[H_W-1] ? DOT_W'(-c_in) : DOT_W'(c_in);
         z3_ff   <= (a2_ff == '0);

         // 25x25 partial products
         hll_ff <= (2*HALF_LO)'(mh3_ff[HALF_LO-1:0] * mh3_ff[HALF_LO-1:0]);
         hlh_ff <= (2*HALF_LO)'({1'b0, mh3_ff[DOT_W-1:HALF_LO]} * mh3_ff[HALF_LO-1:0]);
         hhh_ff <= (2*HALF_LO)'({1'b0, mh3_ff[DOT_W-1:HALF_LO]}
                                * {1'b0, mh3_ff[DOT_W-1:HALF_LO]});
         all_ff <= (2*HALF_LO)'(a3_ff[HALF_LO-1:0] * mc3_ff[HALF_LO-1:0]);
         alh_ff <= (2*HALF_LO)'(a3_ff[HALF_LO-1:0] * {1'b0, mc3_ff[DOT_W-1:HALF_LO]});
         ahl_ff <= (2*HALF_LO)'({1'b0, a3_ff[DOT_W-1:HALF_LO]} * mc3_ff[HALF_LO-1:0]);
         ahh_ff <= (2*HALF_LO)'({1'b0, a3_ff[DOT_W-1:HALF_LO]}
                                * {1'b0, mc3_ff[DOT_W-1:HALF_LO]});
         a4_ff   <= a3_ff;
         mh4_ff  <= mh3_ff;
         hn4_ff  <= hn3_ff;
         cle4_ff <= cle3_ff;
         z4_ff   <= z3_ff;

         hsq5_ff <= (DISC_W'(hhh_ff) << (2 * HALF_LO)) + (DISC_W'(hlh_ff) << (HALF_LO + 1))
                  + DISC_W'(hll_ff);
         ac5_ff  <= (DISC_W'(ahh_ff) << (2 * HALF_LO))
                  + ((DISC_W'(alh_ff) + DISC_W'(ahl_ff)) << HALF_LO) + DISC_W'(all_ff);
         a5_ff   <= a4_ff;
         mh5_ff  <= mh4_ff;
         hn5_ff  <= hn4_ff;
         cle5_ff <= cle4_ff;
         z5_ff   <= z4_ff;

         job_ff <= job_in;
      end
   end

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (v_ff[5] && job_full) |=> (v_ff[5] && $stable(job_ff)))
      else $error("front output changed while stalled");

   a_zero_dir: assert property (@(posedge clock) disable iff (reset)
      (v_ff[5] && job_ff.a == '0) |-> (job_ff.decided && job_ff.outcome == OUT_ZERO_DIR))
      else $error("zero direction not classified");

endmodule

// File: rtl/rhsi_back.sv
// Back end: pipelined integer square root, root test and restoring divide.
// Depends on rhsi_pkg. One stall enable covers every stage.
module rhsi_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   output logic                    job_pop,
   input  rhsi_pkg::job_type       job,
   output logic                    res_valid,
   output rhsi_pkg::result_type    res,
   input  logic                    res_full
);
   import rhsi_pkg::*;

   localparam int SQ_STEPS  = ROOT_W;
   localparam int DIV_STEPS = DIST_W;

   typedef struct packed {
      logic [DISC_W-1:0] rest;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [DOT_W-1:0]  a;
      logic [DOT_W-1:0]  mag_h;
      logic              h_neg;
      logic              decided;
      outcome_type       outcome;
   } sq_type;

   typedef struct packed {
      logic [DOT_W-1:0]  rem;
      logic [DIST_W-1:0] low;
      logic [DIST_W-1:0] quo;
      logic [DOT_W-1:0]  a;
      logic              ovf;
      logic              decided;
      outcome_type       outcome;
   } dv_type;

   logic                    run;
   logic [SQ_STEPS:0]       vsq_ff;
   logic [DIV_STEPS:0]      vdv_ff;
   logic                    vres_ff;
   sq_type                  sq_ff [SQ_STEPS+1];
   dv_type                  dv_ff [DIV_STEPS+1];
   dv_type                  dv_in;
   result_type              res_ff, res_in;
   logic [NUM_W-1:0]        num;

   assign run       = !(vres_ff && res_full);
   assign job_pop   = run && job_valid;
   assign res_valid = vres_ff;
   assign res       = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vsq_ff  <= '0;
         vdv_ff  <= '0;
         vres_ff <= 1'b0;
      end else if (run) begin
         vsq_ff  <= {vsq_ff[SQ_STEPS-1:0], job_valid};
         vdv_ff  <= {vdv_ff[DIV_STEPS-1:0], vsq_ff[SQ_STEPS]};
         vres_ff <= vdv_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         sq_ff[0].rest    <= job.disc;
         sq_ff[0].rem     <= '0;
         sq_ff[0].root    <= '0;
         sq_ff[0].a       <= job.a;
         sq_ff[0].mag_h   <= job.mag_h;
         sq_ff[0].h_neg   <= job.h_neg;
         sq_ff[0].decided <= job.decided;
         sq_ff[0].outcome <= job.outcome;
      end
   end

   // one result bit per stage, two discriminant bits consumed
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
      sq_type           nxt;
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] diff;
      always_comb begin
         nxt   = sq_ff[k];
         trial = {sq_ff[k].rem, sq_ff[k].rest[DISC_W-1 -: 2]};
         diff  = trial - (REM_W+2)'({sq_ff[k].root, 2'b01});
         nxt.rest = sq_ff[k].rest << 2;
         if (!diff[REM_W+1]) begin
            nxt.rem  = diff[REM_W-1:0];
            nxt.root = {sq_ff[k].root[ROOT_W-2:0], 1'b1};
         end else begin
            nxt.rem  = trial[REM_W-1:0];
            nxt.root = {sq_ff[k].root[ROOT_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (run) begin
            sq_ff[k+1] <= nxt;
         end
      end
   end

   // root ahead test and divider setup
   always_comb begin
      num = NUM_W'(sq_ff[SQ_STEPS].mag_h - sq_ff[SQ_STEPS].root) << FRAC_BITS;
      dv_in.rem     = num[NUM_W-1:DIST_W];
      dv_in.low     = num[DIST_W-1:0];
      dv_in.quo     = '0;
      dv_in.a       = sq_ff[SQ_STEPS].a;
      dv_in.ovf     = (num[NUM_W-1:DIST_W] >= sq_ff[SQ_STEPS].a);
      dv_in.decided = sq_ff[SQ_STEPS].decided;
      dv_in.outcome = sq_ff[SQ_STEPS].outcome;
      if (!sq_ff[SQ_STEPS].decided
          && !(sq_ff[SQ_STEPS].h_neg && sq_ff[SQ_STEPS].mag_h > sq_ff[SQ_STEPS].root)) begin
         dv_in.decided = 1'b1;
         dv_in.outcome = OUT_BEHIND;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         dv_ff[0] <= dv_in;
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dv
      dv_type           nxt;
      logic [DOT_W:0]   trial;
      logic [DOT_W:0]   diff;
      always_comb begin
         nxt   = dv_ff[j];
         trial = {dv_ff[j].rem, dv_ff[j].low[DIST_W-1]};
         diff  = trial - {1'b0, dv_ff[j].a};
         nxt.low = dv_ff[j].low << 1;
         if (!diff[DOT_W]) begin
            nxt.rem = diff[DOT_W-1:0];
            nxt.quo = {dv_ff[j].quo[DIST_W-2:0], 1'b1};
         end else begin
            nxt.rem = trial[DOT_W-1:0];
            nxt.quo = {dv_ff[j].quo[DIST_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (run) begin
            dv_ff[j+1] <= nxt;
         end
      end
   end

   always_comb begin
      res_in.hit      = !dv_ff[DIV_STEPS].decided;
      res_in.outcome  = dv_ff[DIV_STEPS].decided ? dv_ff[DIV_STEPS].outcome : OUT_HIT;
      res_in.distance = dv_ff[DIV_STEPS].decided ? '0 :
                        dv_ff[DIV_STEPS].ovf ? '1 : dv_ff[DIV_STEPS].quo;
   end

   always_ff @(posedge clock) begin
      if (run) begin
         res_ff <= res_in;
      end
   end

   a_hit_code: assert property (@(posedge clock) disable iff (reset)
      vres_ff |-> (res_ff.hit == (res_ff.outcome == OUT_HIT)))
      else $error("hit flag disagrees with outcome");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (vres_ff && !res_ff.hit) |-> (res_ff.distance == '0))
      else $error("distance nonzero on a miss");

endmodule

// File: rtl/ray_unit_hypersphere_intersect.sv
// Top level of the 4D ray / unit hypersphere intersect block.
// Depends on rhsi_pkg, rhsi_front, rhsi_back and rhsi_fifo.
//
// Takes one ray per clock while req_full is low and returns one result per
// ray, in order. A ray passes the front end (products, dot sums,
// discriminant), a 4-entry queue, then the back end: an input register, 49
// square-root stages (one root bit each), a root test stage, 32
// restoring-divide stages and an output register, ahead of a 2-entry result
// queue. Throughput is one transaction per cycle while pop keeps up. A full
// result queue stalls only the back end; the front end keeps accepting until
// the middle queue fills.
module ray_unit_hypersphere_intersect #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [rhsi_pkg::IN_W-1:0]     req_origin_x,
   input  logic [rhsi_pkg::IN_W-1:0]     req_origin_y,
   input  logic [rhsi_pkg::IN_W-1:0]     req_origin_z,
   input  logic [rhsi_pkg::IN_W-1:0]     req_origin_w,
   input  logic [rhsi_pkg::IN_W-1:0]     req_dir_x,
   input  logic [rhsi_pkg::IN_W-1:0]     req_dir_y,
   input  logic [rhsi_pkg::IN_W-1:0]     req_dir_z,
   input  logic [rhsi_pkg::IN_W-1:0]     req_dir_w,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic                          rsp_hit,
   output logic [rhsi_pkg::DIST_W-1:0]   rsp_distance,
   output logic [1:0]                    rsp_outcome
);
   import rhsi_pkg::*;

   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 2;

   logic       front_ready;
   logic       job_valid, job_full, job_pop, job_empty;
   job_type    job_push, job_head;
   logic       res_valid, res_full;
   result_type res, res_head;

   assign req_full = !front_ready;

   rhsi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_push),
      .in_ready (front_ready),
      .origin   ({req_origin_w, req_origin_z, req_origin_y, req_origin_x}),
      .dir      ({req_dir_w, req_dir_z, req_dir_y, req_dir_x}),
      .job_valid(job_valid),
      .job      (job_push),
      .job_full (job_full)
   );

   rhsi_fifo #(.WIDTH($bits(job_type)), .DEPTH(MID_DEPTH)) u_mid_q (
      .clock    (clock),
      .reset    (reset),
      .push     (job_valid),
      .push_data(job_push),
      .full     (job_full),
      .pop      (job_pop),
      .empty    (job_empty),
      .pop_data (job_head)
   );

   rhsi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .job_valid(!job_empty),
      .job_pop  (job_pop),
      .job      (job_head),
      .res_valid(res_valid),
      .res      (res),
      .res_full (res_full)
   );

   rhsi_fifo #(.WIDTH($bits(result_type)), .DEPTH(OUT_DEPTH)) u_out_q (
      .clock    (clock),
      .reset    (reset),
      .push     (res_valid),
      .push_data(res),
      .full     (res_full),
      .pop      (rsp_pop),
      .empty    (rsp_empty),
      .pop_data (res_head)
   );

   assign rsp_hit      = res_head.hit;
   assign rsp_distance = res_head.distance;
   assign rsp_outcome  = res_head.outcome;

endmodule

// File: tb/ray_unit_hypersphere_intersect_tb.sv
// Testbench for ray_unit_hypersphere_intersect: 4D rays against the unit hypersphere.
// Depends on rhsi_pkg and the rtl of the block; predicts each result with exact
// wide integer arithmetic and checks results in order.
`timescale 1ns / 1ps

module ray_unit_hypersphere_intersect_tb;
   import rhsi_pkg::*;

   localparam int FRAC = 16;
   localparam int ONE  = 1 << FRAC;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic [IN_W-1:0]     req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   logic [IN_W-1:0]     req_origin_w = '0;
   logic [IN_W-1:0]     req_dir_x = '0, req_dir_y = '0, req_dir_z = '0, req_dir_w = '0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic                rsp_hit;
   logic [DIST_W-1:0]   rsp_distance;
   logic [1:0]          rsp_outcome;

   result_type          hits_pending[$];
   int                  mismatches = 0;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;

   ray_unit_hypersphere_intersect #(.FRAC_BITS(FRAC)) dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_origin_x(req_origin_x), .req_origin_y(req_origin_y),
      .req_origin_z(req_origin_z), .req_origin_w(req_origin_w),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y),
      .req_dir_z(req_dir_z), .req_dir_w(req_dir_w),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_hit(rsp_hit), .rsp_distance(rsp_distance), .rsp_outcome(rsp_outcome)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("ray_unit_hypersphere_intersect_tb: done, errors");
      $finish;
   end

   // exact nearer-root computation on raw fixed-point values
   function automatic result_type intersect_ray(input logic [3:0][IN_W-1:0] org,
                                                input logic [3:0][IN_W-1:0] dir);
      result_type        res;
      longint            a, h, c, ov, dv;
      longint unsigned   mh, mc, s, cand, n, q;
      logic [127:0]      hsq, ac, disc, quo;
      a = 0; h = 0; c = 0;
      for (int i = 0; i < 4; i++) begin
         ov = longint'($signed(org[i]));
         dv = longint'($signed(dir[i]));
         a += dv * dv;
         h += dv * ov;
         c += ov * ov;
      end
      c -= longint'(1) << (2 * FRAC);
      res.hit = 1'b0;
      res.distance = '0;
      if (a == 0) begin
         res.outcome = OUT_ZERO_DIR;
         return res;
      end
      mh = (h < 0) ? -h : h;
      mc = (c < 0) ? -c : c;
      hsq = 128'(mh) * 128'(mh);
      ac = 128'(a) * 128'(mc);
      if (c <= 0) begin
         disc = hsq + ac;
      end else if (ac > hsq) begin
         res.outcome = OUT_NO_ROOT;
         return res;
      end else begin
         disc = hsq - ac;
      end
      s = 0;
      for (int i = 50; i >= 0; i--) begin
         cand = s | (64'd1 << i);
         if (128'(cand) * 128'(cand) <= disc) s = cand;
      end
      if (h >= 0 || mh <= s) begin
         res.outcome = OUT_BEHIND;
         return res;
      end
      n = mh - s;
      q = n / longint'(a);
      res.hit = 1'b1;
      res.outcome = OUT_HIT;
      if (q >= (64'd1 << (32 - FRAC))) begin
         res.distance = '1;
      end else begin
         quo = (128'(n) << FRAC) / 128'(a);
         res.distance = quo[DIST_W-1:0];
      end
      return res;
   endfunction

   task automatic send_ray(input logic [3:0][IN_W-1:0] org, input logic [3:0][IN_W-1:0] dir);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      {req_origin_w, req_origin_z, req_origin_y, req_origin_x} <= org;
      {req_dir_w, req_dir_z, req_dir_y, req_dir_x} <= dir;
      do @(posedge clock); while (req_full);
      hits_pending.push_back(intersect_ray(org, dir));
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (hits_pending.size() != 0) @(posedge clock);
   endtask

   // result side: check the transaction popped at this edge, then pick next pop
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (hits_pending.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result hit=%0d dist=%h outcome=%0d",
                           rsp_hit, rsp_distance, rsp_outcome);
            end else begin
               want = hits_pending.pop_front();
               if (rsp_hit !== want.hit || rsp_distance !== want.distance ||
                   rsp_outcome !== want.outcome) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp hit=%0d dist=%h outcome=%0d, got %0d %h %0d",
                              want.hit, want.distance, want.outcome,
                              rsp_hit, rsp_distance, rsp_outcome);
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [IN_W-1:0] fx(input int v);
      return v[IN_W-1:0];
   endfunction

   function automatic int clamp24(input longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return int'(v);
   endfunction

   task automatic test_special_cases();
      logic [3:0][IN_W-1:0] o, d;
      // zero direction
      o = '0; d = '0;
      send_ray(o, d);
      o = {4{fx(-8388608)}}; d = '0;
      send_ray(o, d);
      // miss: passes beside the sphere
      o = '0; d = '0; o[1] = fx(2 * ONE); d[0] = fx(ONE);
      send_ray(o, d);
      // pointing away
      o = '0; d = '0; o[0] = fx(2 * ONE); d[0] = fx(ONE);
      send_ray(o, d);
      // origin inside: near root behind
      o = '0; d = '0; d[2] = fx(ONE);
      send_ray(o, d);
      // plain hit, t = 1.0
      o = '0; d = '0; o[3] = fx(2 * ONE); d[3] = fx(-ONE);
      send_ray(o, d);
      // tiny positive root
      o = '0; d = '0; o[0] = fx(ONE + 1); d[0] = fx(-8388608);
      send_ray(o, d);
      // far root saturates
      o = '0; d = '0; o[0] = fx(-100 * ONE); d[0] = fx(1);
      send_ray(o, d);
      // tangent
      o = '0; d = '0; o[0] = fx(-2 * ONE); o[1] = fx(ONE); d[0] = fx(ONE);
      send_ray(o, d);
      // extremes
      o = {4{fx(8388607)}}; d = {4{fx(-8388608)}};
      send_ray(o, d);
      o = {4{fx(-8388608)}}; d = {4{fx(8388607)}};
      send_ray(o, d);
      o = {4{fx(8388607)}}; d = {4{fx(8388607)}};
      send_ray(o, d);
      o = {4{fx(-1)}}; d = {4{fx(1)}};
      send_ray(o, d);
   endtask

   task automatic test_random_rays(input int count);
      logic [3:0][IN_W-1:0] o, d;
      int ov, sel, k, noise;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         k = $urandom_range(0, 6);
         for (int i = 0; i < 4; i++) begin
            if (sel < 70) begin
               // aimed roughly at the sphere from nearby
               ov = int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
               noise = int'($urandom_range(0, 1 << $urandom_range(0, 16)))
                       - (1 << 15);
               o[i] = fx(ov);
               d[i] = fx(clamp24(longint'(-(ov >>> k)) + noise));
            end else if (sel < 85) begin
               o[i] = fx(int'($urandom));
               d[i] = fx(int'($urandom));
            end else begin
               // short directions give long distances
               o[i] = fx(int'($urandom_range(0, 16 * ONE)) - 8 * ONE);
               d[i] = fx(int'($signed(fx(int'($urandom))) >>> $urandom_range(8, 23)));
            end
         end
         send_ray(o, d);
      end
   endtask

   task automatic test_pause_until_drained();
      test_random_rays(20);
      drain_results();
      test_random_rays(20);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 34; recv_idle_pct = 80;
      test_special_cases();
      test_random_rays(250);
      test_pause_until_drained();
      send_idle_pct = 80; recv_idle_pct = 34;
      test_random_rays(250);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random_rays(250);
      drain_results();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && hits_pending.size() == 0) begin
         $display("ray_unit_hypersphere_intersect_tb: done, clean");
      end else begin
         $display("ray_unit_hypersphere_intersect_tb: done, errors");
      end
      $finish;
   end

endmodule
